>>> hw/rtl/fhh_pkg.sv
`default_nettype none

package fhh_pkg;

	// Process phase codes, as seen on the phase field.
	typedef logic [2:0] phase_t;
	localparam phase_t PH_IDLE      = 3'd0;
	localparam phase_t PH_FILL_WAIT = 3'd1;
	localparam phase_t PH_FILLING   = 3'd2;
	localparam phase_t PH_HEAT_WAIT = 3'd3;
	localparam phase_t PH_HEATING   = 3'd4;
	localparam phase_t PH_HOLDING   = 3'd5;
	localparam phase_t PH_ALARM     = 3'd6;

	// Configuration register map: register n sits at byte address 4*n.
	localparam int ADDR_W = 4;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_WATER_TARGET = 2'd0;
	localparam reg_idx_t REG_TEMP_TARGET  = 2'd1;
	localparam reg_idx_t REG_TIME_TARGET  = 2'd2;

	localparam logic [9:0] WATER_TARGET_RST = 10'd70;
	localparam logic [7:0] TEMP_TARGET_RST  = 8'd25;
	localparam logic [9:0] TIME_TARGET_RST  = 10'd2;

	// Flow meter: ten liters per thirty-three pulses.
	localparam logic [5:0] PULSE_STEP = 6'd10;
	localparam logic [5:0] PULSE_MOD  = 6'd33;
	localparam logic [5:0] SEC_PER_MIN = 6'd60;
	localparam logic [9:0] COUNT_MAX  = 10'd1023;

	typedef struct packed {
		logic       start_req;
		logic       second_tick;
		logic       flow_pulse;
		logic       sample_valid;
		logic [9:0] adc_sample;
		logic       skip;
		logic       alarm_off;
	} item_t;

	typedef struct packed {
		logic [9:0] water_target;
		logic [7:0] temp_target;
		logic [9:0] time_target;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [9:0]  liters;
		logic [5:0]  pulse_rem;
		logic [10:0] temp;
		logic [9:0]  minutes;
		logic [5:0]  seconds;
	} state_t;

	// Temperature = floor(adc * 6 / 5) = adc + floor(adc / 5).
	// The fifth uses a reciprocal of 205/1024, exact for all 10-bit inputs.
	function automatic logic [10:0] adc_to_temp(input logic [9:0] adc);
		logic [19:0] prod;
		prod = {10'd0, adc} * 20'd205;
		return {1'b0, adc} + {1'b0, prod[19:10]};
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fhh_in_if.sv
`default_nettype none

interface fhh_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic       second_tick;
	logic       flow_pulse;
	logic       sample_valid;
	logic [9:0] adc_sample;
	logic       skip;
	logic       alarm_off;

	modport source (
		output valid, start_req, second_tick, flow_pulse, sample_valid, adc_sample, skip,
		       alarm_off,
		input  ready
	);
	modport sink (
		input  valid, start_req, second_tick, flow_pulse, sample_valid, adc_sample, skip,
		       alarm_off,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/fhh_out_if.sv
`default_nettype none

interface fhh_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  phase;
	logic        water_valve;
	logic        steam_valve;
	logic        alarm_on;
	logic [9:0]  liters_done;
	logic [10:0] temp_now;
	logic [9:0]  minutes_done;
	logic [5:0]  seconds_part;

	modport source (
		output valid, phase, water_valve, steam_valve, alarm_on, liters_done, temp_now,
		       minutes_done, seconds_part,
		input  ready
	);
	modport sink (
		input  valid, phase, water_valve, steam_valve, alarm_on, liters_done, temp_now,
		       minutes_done, seconds_part,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/fhh_apb_regs.sv
`default_nettype none

module fhh_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fhh_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output fhh_pkg::cfg_t                    cfg
);

	fhh_pkg::cfg_t    cfg_q;
	fhh_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.water_target <= fhh_pkg::WATER_TARGET_RST;
			cfg_q.temp_target  <= fhh_pkg::TEMP_TARGET_RST;
			cfg_q.time_target  <= fhh_pkg::TIME_TARGET_RST;
		end else if (wr_en) begin
			case (idx)
				fhh_pkg::REG_WATER_TARGET: cfg_q.water_target <= pwdata[9:0];
				fhh_pkg::REG_TEMP_TARGET:  cfg_q.temp_target  <= pwdata[7:0];
				fhh_pkg::REG_TIME_TARGET:  cfg_q.time_target  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero elsewhere.
	always_comb begin
		case (idx)
			fhh_pkg::REG_WATER_TARGET: prdata = {22'd0, cfg_q.water_target};
			fhh_pkg::REG_TEMP_TARGET:  prdata = {24'd0, cfg_q.temp_target};
			fhh_pkg::REG_TIME_TARGET:  prdata = {22'd0, cfg_q.time_target};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/fhh_next.sv
`default_nettype none

module fhh_next (
	input  wire fhh_pkg::item_t  item,
	input  wire fhh_pkg::state_t cur,
	input  wire fhh_pkg::cfg_t   cfg,
	output fhh_pkg::state_t      nxt
);

	fhh_pkg::phase_t p0;
	logic [5:0]      rem_sum;
	logic [5:0]      sec_inc;
	logic            fill_done;
	logic            heat_done;
	logic            hold_done;
	logic            hold_zero;

	// Counters first, then the phase transitions that look at them.
	always_comb begin
		nxt      = cur;
		p0       = (cur.phase > fhh_pkg::PH_ALARM) ? fhh_pkg::PH_IDLE : cur.phase;
		nxt.phase = p0;
		rem_sum  = cur.pulse_rem + fhh_pkg::PULSE_STEP;
		sec_inc  = cur.seconds + 6'd1;

		// A new temperature reading is taken in any phase.
		if (item.sample_valid) begin
			nxt.temp = fhh_pkg::adc_to_temp(item.adc_sample);
		end

		// Flow pulses count while waiting to fill and while filling.
		if (item.flow_pulse && (p0 inside {fhh_pkg::PH_FILL_WAIT, fhh_pkg::PH_FILLING})) begin
			if (rem_sum >= fhh_pkg::PULSE_MOD) begin
				nxt.pulse_rem = rem_sum - fhh_pkg::PULSE_MOD;
				if (cur.liters != fhh_pkg::COUNT_MAX) begin
					nxt.liters = cur.liters + 10'd1;
				end
			end else begin
				nxt.pulse_rem = rem_sum;
			end
		end

		// Hold timer: seconds wrap into saturating minutes.
		if (item.second_tick && p0 == fhh_pkg::PH_HOLDING) begin
			if (sec_inc >= fhh_pkg::SEC_PER_MIN) begin
				nxt.seconds = 6'd0;
				if (cur.minutes != fhh_pkg::COUNT_MAX) begin
					nxt.minutes = cur.minutes + 10'd1;
				end
			end else begin
				nxt.seconds = sec_inc;
			end
		end

		fill_done = nxt.liters >= cfg.water_target;
		heat_done = nxt.temp >= {3'd0, cfg.temp_target};
		hold_done = nxt.minutes >= cfg.time_target;
		hold_zero = cfg.time_target == 10'd0;

		// Events act only in the starting phase; target checks cascade.
		case (p0)
			fhh_pkg::PH_FILL_WAIT: begin
				if (item.second_tick) begin
					nxt.phase = fill_done ? fhh_pkg::PH_HEAT_WAIT : fhh_pkg::PH_FILLING;
				end
			end
			fhh_pkg::PH_FILLING: begin
				if (fill_done || item.skip) begin
					nxt.phase = fhh_pkg::PH_HEAT_WAIT;
				end
			end
			fhh_pkg::PH_HEAT_WAIT: begin
				if (item.second_tick) begin
					if (heat_done) begin
						nxt.minutes = 10'd0;
						nxt.seconds = 6'd0;
						nxt.phase   = hold_zero ? fhh_pkg::PH_ALARM : fhh_pkg::PH_HOLDING;
					end else begin
						nxt.phase = fhh_pkg::PH_HEATING;
					end
				end
			end
			fhh_pkg::PH_HEATING: begin
				if (heat_done || item.skip) begin
					nxt.minutes = 10'd0;
					nxt.seconds = 6'd0;
					nxt.phase   = hold_zero ? fhh_pkg::PH_ALARM : fhh_pkg::PH_HOLDING;
				end
			end
			fhh_pkg::PH_HOLDING: begin
				if (hold_done || item.skip) begin
					nxt.phase = fhh_pkg::PH_ALARM;
				end
			end
			fhh_pkg::PH_ALARM: begin
				if (item.alarm_off) begin
					nxt.phase = fhh_pkg::PH_IDLE;
				end
			end
			default: begin
				// Idle: a start clears the counters.
				if (item.start_req) begin
					nxt.liters    = 10'd0;
					nxt.pulse_rem = 6'd0;
					nxt.minutes   = 10'd0;
					nxt.seconds   = 6'd0;
					nxt.phase     = fhh_pkg::PH_FILL_WAIT;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/fill_heat_hold_cycle_sequencer.sv
// Path: an accepted input beat passes the input register, then the
// state/result register, before it leaves as a result beat.
// Throughput: one item per cycle while results are taken; a stalled result
// lets the input register take one more beat, then holds the input.
// Reset: arst_n clears the phase to idle and all counters to zero, and
// loads the targets with 70 liters, 25 degrees and 2 minutes.
`default_nettype none

module fill_heat_hold_cycle_sequencer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fhh_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	fhh_in_if.sink                          item,
	fhh_out_if.source                       result
);

	fhh_pkg::cfg_t   cfg;
	fhh_pkg::item_t  item_s1;
	logic            item_vld_s1;
	fhh_pkg::state_t state_q;
	fhh_pkg::state_t state_nxt;
	logic            result_vld_q;
	logic            fire;

	fhh_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fhh_next u_next (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt)
	);

	// The held item is processed whenever the result register is free.
	assign fire       = item_vld_s1 && (!result_vld_q || result.ready);
	assign item.ready = !item_vld_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (item.ready) begin
			item_vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.start_req    <= item.start_req;
			item_s1.second_tick  <= item.second_tick;
			item_s1.flow_pulse   <= item.flow_pulse;
			item_s1.sample_valid <= item.sample_valid;
			item_s1.adc_sample   <= item.adc_sample;
			item_s1.skip         <= item.skip;
			item_s1.alarm_off    <= item.alarm_off;
		end
	end

	// Process state doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			result_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_nxt;
			end
			if (fire) begin
				result_vld_q <= 1'b1;
			end else if (result.ready) begin
				result_vld_q <= 1'b0;
			end
		end
	end

	// Result beat.
	assign result.valid        = result_vld_q;
	assign result.phase        = state_q.phase;
	assign result.water_valve  = state_q.phase == fhh_pkg::PH_FILLING;
	assign result.steam_valve  = state_q.phase == fhh_pkg::PH_HEATING;
	assign result.alarm_on     = state_q.phase == fhh_pkg::PH_ALARM;
	assign result.liters_done  = state_q.liters;
	assign result.temp_now     = state_q.temp;
	assign result.minutes_done = state_q.minutes;
	assign result.seconds_part = state_q.seconds;

`ifndef NO_ASSERTIONS
	a_seconds_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.seconds < fhh_pkg::SEC_PER_MIN)
		else $error("hold seconds counter out of range");

	a_pulse_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pulse_rem < fhh_pkg::PULSE_MOD)
		else $error("pulse remainder out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (item_vld_s1 && result_vld_q && !result.ready))
		else $error("input stalled without a blocked result");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.start_req && state_q.phase == fhh_pkg::PH_IDLE)
		|=> (state_q.liters == 10'd0 && state_q.minutes == 10'd0
		     && state_q.phase == fhh_pkg::PH_FILL_WAIT))
		else $error("start did not clear the counters");
`endif

endmodule

`default_nettype wire
